// File: src/ilid_pkg.sv
package ilid_pkg;

    // storage geometry
    localparam int CAPACITY = 16;
    localparam int ITEM_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);

    // fixed port field widths
    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int READ_W   = 32;
    localparam int CNT_W    = 5;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OVERWRITE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd5;

    // per-cycle action broadcast to every cell
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_HOLD   = 2'd0;
    localparam t_mode MODE_WRITE  = 2'd1;
    localparam t_mode MODE_INSERT = 2'd2;
    localparam t_mode MODE_DELETE = 2'd3;

    typedef struct packed {
        t_mode             mode;
        logic [IDX_W-1:0]  idx;
        logic [ITEM_W-1:0] data;
    } t_cell_cmd;

endpackage

// File: src/ilid_cell.sv
module ilid_cell
    import ilid_pkg::*;
(
    input  logic              i_clk,
    input  logic [IDX_W-1:0]  i_idx,
    input  t_cell_cmd         i_cmd,
    input  logic [ITEM_W-1:0] i_left,
    input  logic [ITEM_W-1:0] i_right,
    output logic [ITEM_W-1:0] o_data
);

    logic [ITEM_W-1:0] r_data;
    logic [ITEM_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.mode)
            MODE_WRITE: begin
                if (i_idx == i_cmd.idx) n_data = i_cmd.data;
            end
            MODE_INSERT: begin
                if (i_idx > i_cmd.idx)       n_data = i_left;
                else if (i_idx == i_cmd.idx) n_data = i_cmd.data;
            end
            MODE_DELETE: begin
                if (i_idx >= i_cmd.idx) n_data = i_right;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: src/indexed_list_insert_delete.sv
// Ordered list of up to CAPACITY words kept in a row of cells, one word per
// cell. Every request (push, pop, get, overwrite, insert, delete) is decoded
// in the cycle it is accepted; insert and delete move every later word one
// cell over in that same edge, so one beat can be accepted every clock while
// the result side keeps up. The result (read word, status, new count) sits in
// an output register until taken; a new beat is accepted whenever that
// register is empty or being drained. Refused requests (full, empty, index
// out of range, unknown kind) return status 1, read word 0 and the unchanged
// count. Stored words are not cleared at reset; only the count and the
// output valid flag are.
module indexed_list_insert_delete
    import ilid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [POS_W-1:0]   i_position,
    input  logic [VALUE_W-1:0] i_item_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [READ_W-1:0]  o_read_value,
    output logic               o_status,
    output logic [CNT_W-1:0]   o_element_count
);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // control state
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result payload
    logic [READ_W-1:0] r_read_value;
    logic              r_status;

    logic accept;
    logic full;
    logic empty;
    logic pos_lt_cnt;
    logic pos_le_cnt;
    logic ok;
    logic rd_en;
    logic [IDX_W-1:0] rd_idx;
    t_cell_cmd cmd;

    logic [ITEM_W-1:0] cell_data [CAPACITY];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign full       = (r_count == CNT_FULL);
    assign empty      = (r_count == '0);
    assign pos_lt_cnt = (CNT_W'(i_position) < r_count);
    assign pos_le_cnt = (CNT_W'(i_position) <= r_count);

    // request decode
    always_comb begin
        ok       = 1'b0;
        rd_en    = 1'b0;
        rd_idx   = i_position[IDX_W-1:0];
        n_count  = r_count;
        cmd.mode = MODE_HOLD;
        cmd.idx  = i_position[IDX_W-1:0];
        cmd.data = ITEM_W'(i_item_value);
        unique case (i_kind)
            KIND_PUSH: begin
                ok      = !full;
                cmd.idx = r_count[IDX_W-1:0];
                if (ok) begin
                    cmd.mode = MODE_WRITE;
                    n_count  = r_count + CNT_ONE;
                end
            end
            KIND_POP: begin
                ok     = !empty;
                rd_en  = 1'b1;
                rd_idx = IDX_W'(r_count - CNT_ONE);
                if (ok) n_count = r_count - CNT_ONE;
            end
            KIND_GET: begin
                ok    = pos_lt_cnt;
                rd_en = 1'b1;
            end
            KIND_OVERWRITE: begin
                ok = pos_lt_cnt;
                if (ok) cmd.mode = MODE_WRITE;
            end
            KIND_INSERT: begin
                ok = pos_le_cnt && !full;
                if (ok) begin
                    cmd.mode = MODE_INSERT;
                    n_count  = r_count + CNT_ONE;
                end
            end
            KIND_DELETE: begin
                ok = pos_lt_cnt;
                if (ok) begin
                    cmd.mode = MODE_DELETE;
                    n_count  = r_count - CNT_ONE;
                end
            end
            default: ok = 1'b0;
        endcase
        if (!accept) cmd.mode = MODE_HOLD;
    end

    // row of storage cells; each sees its two neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ITEM_W-1:0] left;
        logic [ITEM_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_data[g+1];
        end

        ilid_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_cmd   (cmd),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[g])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= !ok;
            r_read_value <= (ok && rd_en) ? READ_W'(cell_data[rd_idx]) : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_value    = r_read_value;
    assign o_status        = r_status;
    assign o_element_count = r_count;

endmodule

// File: tb/sv/indexed_list_insert_delete_tb.sv
module indexed_list_insert_delete_tb;
    import ilid_pkg::*;

    // kinds the block does not decode; both must come back refused
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 8;     // output register plus margin
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any beat
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 610;

    typedef struct packed {
        logic [READ_W-1:0] read_value;
        logic              status;
        logic [CNT_W-1:0]  element_count;
    } t_list_result;

    // DUT signals; the inputs start at known values from time zero
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_ready;
    logic [KIND_W-1:0]  i_kind       = KIND_PUSH;
    logic [POS_W-1:0]   i_position   = '0;
    logic [VALUE_W-1:0] i_item_value = '0;
    logic               o_out_valid;
    logic               i_out_ready  = 1'b0;
    logic [READ_W-1:0]  o_read_value;
    logic               o_status;
    logic [CNT_W-1:0]   o_element_count;

    // shadow copy of the list, updated once per accepted request
    logic [ITEM_W-1:0] list_words [CAPACITY];
    int unsigned       list_len;
    t_list_result      pending_results [$];

    // idle percentages for the two sides, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // bookkeeping
    int unsigned beats_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned refused_count  = 0;
    int unsigned full_hits      = 0;
    int unsigned empty_hits     = 0;
    int unsigned quiet_cycles   = 0;

    indexed_list_insert_delete uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_position      (i_position),
        .i_item_value    (i_item_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_element_count (o_element_count)
    );

    always #2 i_clk = ~i_clk;

    // Apply one request to the shadow list and return what the block owes.
    // Refusals leave the list alone and report the unchanged count.
    function automatic t_list_result apply_request(logic [KIND_W-1:0]  kind,
                                                   logic [POS_W-1:0]   pos,
                                                   logic [VALUE_W-1:0] val);
        t_list_result      res;
        logic              ok;
        logic [ITEM_W-1:0] word;
        logic [ITEM_W-1:0] rd;
        int unsigned       p;
        ok   = 1'b0;
        rd   = '0;
        word = val[ITEM_W-1:0];
        p    = pos;
        case (kind)
            KIND_PUSH: begin
                if (list_len < CAPACITY) begin
                    list_words[list_len] = word;
                    list_len++;
                    ok = 1'b1;
                end
            end
            KIND_POP: begin
                if (list_len > 0) begin
                    list_len--;
                    rd = list_words[list_len];
                    ok = 1'b1;
                end
            end
            KIND_GET: begin
                if (p < list_len) begin
                    rd = list_words[p];
                    ok = 1'b1;
                end
            end
            KIND_OVERWRITE: begin
                if (p < list_len) begin
                    list_words[p] = word;
                    ok = 1'b1;
                end
            end
            KIND_INSERT: begin
                if (p <= list_len && list_len < CAPACITY) begin
                    for (int i = list_len; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = word;
                    list_len++;
                    ok = 1'b1;
                end
            end
            KIND_DELETE: begin
                if (p < list_len) begin
                    for (int i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    ok = 1'b1;
                end
            end
            default: ok = 1'b0;   // spare kinds
        endcase
        res.read_value    = ok ? READ_W'(rd) : '0;
        res.status        = ok ? STATUS_DONE : STATUS_REFUSED;
        res.element_count = CNT_W'(list_len);
        if (!ok)
            refused_count++;
        if (list_len == CAPACITY)
            full_hits++;
        if (list_len == 0)
            empty_hits++;
        return res;
    endfunction

    // Send one request beat. Random idle cycles go in front; valid is only
    // lowered while idling, so back-to-back beats keep it high.
    task automatic send_beat(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                             logic [VALUE_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_position   <= pos;
        i_item_value <= val;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pending_results.push_back(apply_request(kind, pos, val));
        beats_sent++;
    endtask

    // Result side: random back-pressure, set per phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: every result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: rd=%h st=%0d cnt=%0d",
                             o_read_value, o_status, o_element_count);
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.read_value || o_status !== want.status ||
                    o_element_count !== want.element_count) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch on result %0d: got rd=%h st=%0d cnt=%0d,",
                                 results_seen, o_read_value, o_status,
                                 o_element_count,
                                 " want rd=%h st=%0d cnt=%0d",
                                 want.read_value, want.status, want.element_count);
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Requests on an empty list: pop, get at the top position, delete, and
    // insert past the end must all be refused.
    task automatic test_empty_list();
        send_beat(KIND_POP, '0, $urandom);
        send_beat(KIND_GET, '1, $urandom);
        send_beat(KIND_DELETE, '0, $urandom);
        send_beat(KIND_INSERT, POS_W'(1), $urandom);
    endtask

    task automatic test_spare_kinds();
        send_beat(KIND_SPARE_6, POS_W'($urandom_range(31)), $urandom);
        send_beat(KIND_SPARE_7, POS_W'($urandom_range(31)), $urandom);
    endtask

    // Build the list up to capacity with inserts at head, tail and middle,
    // then check that push and insert on a full list are refused.
    task automatic test_fill_to_capacity();
        send_beat(KIND_INSERT, '0, '0);
        send_beat(KIND_PUSH, '0, '1);
        send_beat(KIND_INSERT, POS_W'(list_len), $urandom);
        send_beat(KIND_INSERT, POS_W'(1), $urandom);
        while (list_len < CAPACITY)
            send_beat(KIND_PUSH, POS_W'($urandom_range(31)), $urandom);
        send_beat(KIND_PUSH, '0, $urandom);
        send_beat(KIND_INSERT, '0, $urandom);
    endtask

    // Boundary positions on a full list: last slot, one past it, head.
    task automatic test_edge_positions();
        send_beat(KIND_GET, POS_W'(CAPACITY - 1), $urandom);
        send_beat(KIND_GET, POS_W'(CAPACITY), $urandom);
        send_beat(KIND_OVERWRITE, '0, $urandom);
        send_beat(KIND_DELETE, POS_W'(CAPACITY), $urandom);
        send_beat(KIND_DELETE, '0, $urandom);
        send_beat(KIND_DELETE, POS_W'(list_len - 1), $urandom);
        send_beat(KIND_POP, '0, $urandom);
    endtask

    // Random traffic. The list drifts between growing and shrinking stretches
    // so it keeps crossing both empty and full; most positions are in range,
    // some are one past the end or arbitrary, and a few beats are noise.
    task automatic test_random_traffic(int unsigned n_items, int unsigned send_pct,
                                       int unsigned recv_pct);
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        logic               growing;
        int unsigned        stretch;
        int unsigned        roll;
        int unsigned        hi;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        growing = 1'b1;
        stretch = $urandom_range(60, 20);
        for (int k = 0; k < n_items; k++) begin
            if (stretch == 0) begin
                growing = ~growing;
                stretch = $urandom_range(60, 20);
            end
            stretch--;
            if ($urandom_range(99) < 6) begin
                kind = KIND_W'($urandom_range(7));
                pos  = POS_W'($urandom_range(31));
            end else begin
                roll = $urandom_range(99);
                if (roll < 30)
                    kind = growing ? KIND_PUSH : KIND_POP;
                else if (roll < 60)
                    kind = growing ? KIND_INSERT : KIND_DELETE;
                else if (roll < 75)
                    kind = KIND_GET;
                else if (roll < 90)
                    kind = KIND_OVERWRITE;
                else if (roll < 95)
                    kind = growing ? KIND_POP : KIND_PUSH;
                else
                    kind = growing ? KIND_DELETE : KIND_INSERT;
                roll = $urandom_range(19);
                hi = (kind == KIND_INSERT) ? list_len : (list_len > 0 ? list_len - 1 : 0);
                if (roll == 0)
                    pos = POS_W'($urandom_range(31));
                else if (roll == 1)
                    pos = POS_W'(hi + 1);
                else
                    pos = POS_W'($urandom_range(hi));
            end
            case ($urandom_range(9))
                0:       val = '0;
                1:       val = '1;
                default: val = $urandom;
            endcase
            send_beat(kind, pos, val);
        end
    endtask

    initial begin
        list_len = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part runs under the first phase's idle pattern
        send_idle_pct = 23;
        recv_idle_pct = 73;
        test_empty_list();
        test_spare_kinds();
        test_fill_to_capacity();
        test_edge_positions();

        test_random_traffic(PHASE_ITEMS, 23, 73);
        test_random_traffic(PHASE_ITEMS, 73, 23);
        test_random_traffic(PHASE_ITEMS, 0, 0);
        i_in_valid <= 1'b0;

        // drain: outstanding results first, then DRAIN_CYCLES more for strays
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            mismatch_count++;

        $display("sent %0d requests, checked %0d results, %0d refused",
                 beats_sent, results_seen, refused_count);
        $display("list reached full %0d times and empty %0d times, %0d mismatches",
                 full_hits, empty_hits, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
